>>> hw/rtl/tgad_pkg.sv
// Shared types and constants for the TGA image decoder.
// Holds header offsets, image type codes, result kinds, error codes and the result record.
// No dependencies.
package tgad_pkg;

   // result kinds (rsp_tuser)
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_PIXEL  = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_IMAGE_TYPE = 3'd1;
   localparam logic [2:0] ERR_COLORMAP   = 3'd2;
   localparam logic [2:0] ERR_PIXEL_SIZE = 3'd3;
   localparam logic [2:0] ERR_SIZE       = 3'd4;

   // header byte offsets
   localparam logic [4:0] HDR_ID_LEN     = 5'd0;
   localparam logic [4:0] HDR_CMAP_TYPE  = 5'd1;
   localparam logic [4:0] HDR_IMAGE_TYPE = 5'd2;
   localparam logic [4:0] HDR_WIDTH_LO   = 5'd12;
   localparam logic [4:0] HDR_WIDTH_HI   = 5'd13;
   localparam logic [4:0] HDR_HEIGHT_LO  = 5'd14;
   localparam logic [4:0] HDR_HEIGHT_HI  = 5'd15;
   localparam logic [4:0] HDR_DEPTH      = 5'd16;
   localparam logic [4:0] HDR_DESCRIPTOR = 5'd17;

   // image type field values in the file
   localparam logic [7:0] TYPE_TRUECOLOR     = 8'd2;
   localparam logic [7:0] TYPE_GREY          = 8'd3;
   localparam logic [7:0] TYPE_RLE_TRUECOLOR = 8'd10;

   // internal image kinds
   localparam logic [1:0] IMG_TRUECOLOR = 2'd0;
   localparam logic [1:0] IMG_GREY      = 2'd1;
   localparam logic [1:0] IMG_RLE       = 2'd2;

   // pixel depth field values and bytes per pixel
   localparam logic [7:0] DEPTH_8  = 8'd8;
   localparam logic [7:0] DEPTH_24 = 8'd24;
   localparam logic [7:0] DEPTH_32 = 8'd32;
   localparam logic [2:0] BPP_NONE = 3'd0;
   localparam logic [2:0] BPP_GREY = 3'd1;
   localparam logic [2:0] BPP_RGB  = 3'd3;
   localparam logic [2:0] BPP_RGBA = 3'd4;

   localparam int TOP_DOWN_BIT = 5;
   localparam int RUN_FLAG_BIT = 7;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 112;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [15:0] dest_row;
      logic [15:0] column;
      logic [7:0]  run_length;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic [2:0]  error_code;
      logic        end_of_image;
   } rsp_type;

endpackage

>>> hw/rtl/tga_image_decoder.sv
// TGA image decoder top level: header parser, pixel and RLE packet decoder, result register.
// Depends on tgad_pkg.

// Takes one TGA file byte per cycle (req_tuser marks the first header byte and restarts the
// decoder) and returns header, pixel-run and error items through a one-entry result register.
// Each byte is handled in the cycle it is accepted; the input stalls only while the result
// register is full and rsp_tready is low, and after an RLE run packet of more than one pixel:
// its end position is found by a shift-subtract divider (column plus run length by image
// width), and the last byte of the following pixel waits for it; the packet byte and the
// earlier pixel bytes are still taken while the divider runs.
module tga_image_decoder (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [tgad_pkg::REQ_DATA_W-1:0] req_tdata,   // [7:0] data_byte
   input  logic                           req_tuser,   // start_of_file
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [47:32] dest_row,
   // [63:48] column, [71:64] run_length, [87:72] image_width, [103:88] image_height,
   // [106:104] error_code, [111:107] zero
   output logic [tgad_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]                     rsp_tuser,   // kind
   output logic                           rsp_tlast,   // end_of_image
   input  logic                           csr_wr_en,
   input  logic [7:0]                     csr_wr_data  // alpha_fill
);

   typedef enum logic [2:0] {PH_IDLE, PH_HEAD, PH_SKIP, PH_PACKET, PH_PIXEL} phase_type;

   phase_type         phase_ff, phase_in;
   logic [4:0]        header_pos_ff, header_pos_in;
   logic [7:0]        skip_ff, skip_in;
   logic [1:0]        img_kind_ff, img_kind_in;
   logic [2:0]        bpp_ff, bpp_in;
   logic              top_down_ff, top_down_in;
   logic [15:0]       width_ff, width_in;
   logic [15:0]       height_ff, height_in;
   logic [31:0]       area_ff, area_in;
   logic [28:0]       pix_left_ff, pix_left_in;
   logic [15:0]       row_ff, row_in;
   logic [15:0]       col_ff, col_in;
   logic [7:0]        packet_ff, packet_in;
   logic              is_run_ff, is_run_in;
   logic [1:0]        bip_ff, bip_in;
   logic [23:0]       held_ff, held_in;
   logic [2:0]        err_ff, err_in;
   logic [7:0]        alpha_fill_ff, alpha_fill_in;
   logic              div_busy_ff, div_busy_in;
   logic [2:0]        div_step_ff, div_step_in;
   logic [16:0]       div_rem_ff, div_rem_in;
   logic              rsp_valid_ff, rsp_valid_in;
   tgad_pkg::rsp_type rsp_ff, rsp_in;

   tgad_pkg::rsp_type res;
   logic              res_valid;
   logic              req_acc;
   logic [7:0]        in_byte;
   logic              div_stall;
   logic              pix_last;
   logic [2:0]        hdr_code;
   logic [7:0]        n_req, n_clip;
   logic [28:0]       rem_after;
   logic [7:0]        pkt_after;
   logic [16:0]       col_inc;
   logic [16:0]       col_plus_n;
   logic [15:0]       dest_row;
   logic [7:0]        pix_red, pix_green, pix_blue, pix_alpha;
   logic [23:0]       div_shift;
   logic              div_ge;
   logic [16:0]       div_rem_next;
   logic [15:0]       div_bit;
   phase_type         data_phase;

   assign in_byte   = req_tdata[7:0];
   assign pix_last  = ({1'b0, bip_ff} + 3'd1) >= bpp_ff;
   // hold the final pixel byte until the run divider has settled row and column
   assign div_stall = div_busy_ff && (phase_ff == PH_PIXEL) && pix_last;
   assign req_tready = (!rsp_valid_ff || rsp_tready) && !div_stall;
   assign req_acc   = req_tvalid && req_tready;
   assign data_phase = (img_kind_ff == tgad_pkg::IMG_RLE) ? PH_PACKET : PH_PIXEL;

   // header checks, first failure wins
   always_comb begin
      if (err_ff != tgad_pkg::ERR_NONE) begin
         hdr_code = err_ff;
      end else if (bpp_ff != tgad_pkg::BPP_RGB && bpp_ff != tgad_pkg::BPP_RGBA &&
                   img_kind_ff != tgad_pkg::IMG_GREY) begin
         hdr_code = tgad_pkg::ERR_PIXEL_SIZE;
      end else if (width_ff == 16'd0 || height_ff == 16'd0 || area_ff[31:29] != 3'd0) begin
         hdr_code = tgad_pkg::ERR_SIZE;
      end else if (bpp_ff == tgad_pkg::BPP_NONE) begin
         hdr_code = tgad_pkg::ERR_PIXEL_SIZE;
      end else begin
         hdr_code = tgad_pkg::ERR_NONE;
      end
   end

   // pixel colour and run geometry
   always_comb begin
      if (bpp_ff < tgad_pkg::BPP_RGB) begin
         pix_red   = in_byte;
         pix_green = in_byte;
         pix_blue  = in_byte;
         pix_alpha = alpha_fill_ff;
      end else if (bpp_ff == tgad_pkg::BPP_RGB) begin
         pix_red   = in_byte;
         pix_green = held_ff[15:8];
         pix_blue  = held_ff[7:0];
         pix_alpha = alpha_fill_ff;
      end else begin
         pix_red   = held_ff[23:16];
         pix_green = held_ff[15:8];
         pix_blue  = held_ff[7:0];
         pix_alpha = in_byte;
      end
      if (img_kind_ff == tgad_pkg::IMG_RLE && is_run_ff) begin
         n_req = (packet_ff == 8'd0) ? 8'd1 : packet_ff;
      end else begin
         n_req = 8'd1;
      end
      // clip the run at the image end
      n_clip     = (29'(n_req) > pix_left_ff) ? pix_left_ff[7:0] : n_req;
      rem_after  = pix_left_ff - 29'(n_clip);
      pkt_after  = (packet_ff > n_clip) ? (packet_ff - n_clip) : 8'd0;
      col_inc    = 17'(col_ff) + 17'd1;
      col_plus_n = 17'(col_ff) + 17'(n_clip);
      dest_row   = top_down_ff ? row_ff : (height_ff - 16'd1 - row_ff);
   end

   // one restoring step per cycle: quotient bit adds to the row, remainder is the column
   assign div_shift    = 24'(width_ff) << div_step_ff;
   assign div_ge       = {7'd0, div_rem_ff} >= div_shift;
   assign div_rem_next = div_ge ? (div_rem_ff - div_shift[16:0]) : div_rem_ff;
   assign div_bit      = 16'd1 << div_step_ff;

   always_comb begin
      phase_in      = phase_ff;
      header_pos_in = header_pos_ff;
      skip_in       = skip_ff;
      img_kind_in   = img_kind_ff;
      bpp_in        = bpp_ff;
      top_down_in   = top_down_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      area_in       = area_ff;
      pix_left_in   = pix_left_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      packet_in     = packet_ff;
      is_run_in     = is_run_ff;
      bip_in        = bip_ff;
      held_in       = held_ff;
      err_in        = err_ff;
      alpha_fill_in = csr_wr_en ? csr_wr_data : alpha_fill_ff;
      div_busy_in   = div_busy_ff;
      div_step_in   = div_step_ff;
      div_rem_in    = div_rem_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      res           = '0;
      res_valid     = 1'b0;

      if (div_busy_ff) begin
         div_rem_in  = div_rem_next;
         div_step_in = div_step_ff - 3'd1;
         if (div_ge) begin
            row_in = row_ff + div_bit;
         end
         if (div_step_ff == 3'd0) begin
            div_busy_in = 1'b0;
            col_in      = div_rem_next[15:0];
         end
      end

      if (req_acc) begin
         if (req_tuser) begin
            // restart: drop whatever image was in progress
            phase_in      = PH_HEAD;
            header_pos_in = 5'd0;
            skip_in       = 8'd0;
            img_kind_in   = tgad_pkg::IMG_TRUECOLOR;
            bpp_in        = tgad_pkg::BPP_NONE;
            top_down_in   = 1'b0;
            row_in        = 16'd0;
            col_in        = 16'd0;
            packet_in     = 8'd0;
            is_run_in     = 1'b0;
            bip_in        = 2'd0;
            held_in       = 24'd0;
            err_in        = tgad_pkg::ERR_NONE;
            div_busy_in   = 1'b0;
         end

         case (phase_in)
            PH_HEAD: begin
               case (header_pos_in)
                  tgad_pkg::HDR_ID_LEN: skip_in = in_byte;
                  tgad_pkg::HDR_CMAP_TYPE: begin
                     if (in_byte != 8'd0) begin
                        err_in = tgad_pkg::ERR_COLORMAP;
                     end
                  end
                  tgad_pkg::HDR_IMAGE_TYPE: begin
                     case (in_byte)
                        tgad_pkg::TYPE_TRUECOLOR:     img_kind_in = tgad_pkg::IMG_TRUECOLOR;
                        tgad_pkg::TYPE_GREY:          img_kind_in = tgad_pkg::IMG_GREY;
                        tgad_pkg::TYPE_RLE_TRUECOLOR: img_kind_in = tgad_pkg::IMG_RLE;
                        default: begin
                           img_kind_in = tgad_pkg::IMG_TRUECOLOR;
                           err_in      = tgad_pkg::ERR_IMAGE_TYPE;
                        end
                     endcase
                  end
                  tgad_pkg::HDR_WIDTH_LO:  width_in  = {width_ff[15:8], in_byte};
                  tgad_pkg::HDR_WIDTH_HI:  width_in  = {in_byte, width_ff[7:0]};
                  tgad_pkg::HDR_HEIGHT_LO: height_in = {height_ff[15:8], in_byte};
                  tgad_pkg::HDR_HEIGHT_HI: height_in = {in_byte, height_ff[7:0]};
                  tgad_pkg::HDR_DEPTH: begin
                     case (in_byte)
                        tgad_pkg::DEPTH_8:  bpp_in = tgad_pkg::BPP_GREY;
                        tgad_pkg::DEPTH_24: bpp_in = tgad_pkg::BPP_RGB;
                        tgad_pkg::DEPTH_32: bpp_in = tgad_pkg::BPP_RGBA;
                        default:            bpp_in = tgad_pkg::BPP_NONE;
                     endcase
                     // size is complete one byte ahead of the checks
                     area_in = 32'(width_ff) * 32'(height_ff);
                  end
                  default: ;
               endcase

               if (header_pos_in >= tgad_pkg::HDR_DESCRIPTOR) begin
                  header_pos_in = 5'd0;
                  top_down_in   = in_byte[tgad_pkg::TOP_DOWN_BIT];
                  err_in        = hdr_code;
                  res_valid     = 1'b1;
                  if (hdr_code != tgad_pkg::ERR_NONE) begin
                     phase_in         = PH_IDLE;
                     res.kind         = tgad_pkg::KIND_ERROR;
                     res.error_code   = hdr_code;
                     res.end_of_image = 1'b1;
                  end else begin
                     row_in           = 16'd0;
                     col_in           = 16'd0;
                     bip_in           = 2'd0;
                     held_in          = 24'd0;
                     pix_left_in      = area_ff[28:0];
                     phase_in         = (skip_ff != 8'd0) ? PH_SKIP : data_phase;
                     res.kind         = tgad_pkg::KIND_HEADER;
                     res.image_width  = width_ff;
                     res.image_height = height_ff;
                  end
               end else begin
                  header_pos_in = header_pos_in + 5'd1;
               end
            end

            PH_SKIP: begin
               skip_in = skip_ff - 8'd1;
               if (skip_in == 8'd0) begin
                  phase_in = data_phase;
               end
            end

            PH_PACKET: begin
               packet_in = {1'b0, in_byte[6:0]} + 8'd1;
               is_run_in = in_byte[tgad_pkg::RUN_FLAG_BIT];
               bip_in    = 2'd0;
               held_in   = 24'd0;
               phase_in  = PH_PIXEL;
            end

            PH_PIXEL: begin
               if (!pix_last) begin
                  held_in = held_ff | (24'(in_byte) << {bip_ff, 3'b000});
                  bip_in  = bip_ff + 2'd1;
               end else begin
                  res_valid      = 1'b1;
                  res.kind       = tgad_pkg::KIND_PIXEL;
                  res.red        = pix_red;
                  res.green      = pix_green;
                  res.blue       = pix_blue;
                  res.alpha      = pix_alpha;
                  res.dest_row   = dest_row;
                  res.column     = col_ff;
                  res.run_length = n_clip;
                  bip_in         = 2'd0;
                  held_in        = 24'd0;
                  pix_left_in    = rem_after;
                  if (rem_after == 29'd0) begin
                     res.end_of_image = 1'b1;
                     phase_in         = PH_IDLE;
                  end else begin
                     if (n_clip == 8'd1) begin
                        if (col_inc == 17'(width_ff)) begin
                           col_in = 16'd0;
                           row_in = row_ff + 16'd1;
                        end else begin
                           col_in = col_inc[15:0];
                        end
                     end else begin
                        div_busy_in = 1'b1;
                        div_step_in = 3'd7;
                        div_rem_in  = col_plus_n;
                     end
                     if (img_kind_ff == tgad_pkg::IMG_RLE) begin
                        packet_in = pkt_after;
                        if (pkt_after == 8'd0) begin
                           phase_in = PH_PACKET;
                        end
                     end
                  end
               end
            end

            default: ;
         endcase
      end

      if (res_valid) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         header_pos_ff <= 5'd0;
         skip_ff       <= 8'd0;
         img_kind_ff   <= tgad_pkg::IMG_TRUECOLOR;
         bpp_ff        <= tgad_pkg::BPP_NONE;
         top_down_ff   <= 1'b0;
         pix_left_ff   <= 29'd0;
         row_ff        <= 16'd0;
         col_ff        <= 16'd0;
         packet_ff     <= 8'd0;
         is_run_ff     <= 1'b0;
         bip_ff        <= 2'd0;
         held_ff       <= 24'd0;
         err_ff        <= tgad_pkg::ERR_NONE;
         alpha_fill_ff <= 8'hff;
         div_busy_ff   <= 1'b0;
         div_step_ff   <= 3'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         header_pos_ff <= header_pos_in;
         skip_ff       <= skip_in;
         img_kind_ff   <= img_kind_in;
         bpp_ff        <= bpp_in;
         top_down_ff   <= top_down_in;
         pix_left_ff   <= pix_left_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         packet_ff     <= packet_in;
         is_run_ff     <= is_run_in;
         bip_ff        <= bip_in;
         held_ff       <= held_in;
         err_ff        <= err_in;
         alpha_fill_ff <= alpha_fill_in;
         div_busy_ff   <= div_busy_in;
         div_step_ff   <= div_step_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      width_ff   <= width_in;
      height_ff  <= height_in;
      area_ff    <= area_in;
      div_rem_ff <= div_rem_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ff.error_code, rsp_ff.image_height, rsp_ff.image_width,
                        rsp_ff.run_length, rsp_ff.column, rsp_ff.dest_row, rsp_ff.alpha,
                        rsp_ff.blue, rsp_ff.green, rsp_ff.red};
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.end_of_image;

   // divider only runs between an RLE run and the next pixel
   a_div_phase: assert property (@(posedge clock) disable iff (reset)
      div_busy_ff |-> (phase_ff == PH_PACKET || phase_ff == PH_PIXEL))
      else $error("run divider busy outside pixel data");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      (!div_busy_ff && !rsp_valid_ff) |-> req_tready)
      else $error("input stalled with no reason");

   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == tgad_pkg::KIND_PIXEL) |-> rsp_ff.run_length != 8'd0)
      else $error("pixel item with empty run");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == tgad_pkg::KIND_ERROR) |->
         (rsp_ff.end_of_image && phase_ff == PH_IDLE) || $past(req_acc && req_tuser))
      else $error("error item without end of image");

endmodule
